// ----- hdl/irpdd_pkg.sv -----
// Package for the IR pulse distance decoder: register indexes, widths,
// button code table and lookup function. No dependencies.
`default_nettype none

package irpdd_pkg;

  localparam int unsigned DurW    = 16;
  localparam int unsigned WordW   = 32;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned LvlW    = 8;
  localparam int unsigned NumCodes = 27;

  typedef enum logic [1:0] {
    REG_ONE_THRESHOLD = 2'd0,
    REG_LOW_MIN       = 2'd1,
    REG_LOW_MAX       = 2'd2,
    REG_GARBAGE_LIMIT = 2'd3
  } cfg_reg_e;

  localparam logic [DurW-1:0] OneThresholdRst = 16'd1400;
  localparam logic [DurW-1:0] LowMinRst       = 16'd400;
  localparam logic [DurW-1:0] LowMaxRst       = 16'd725;
  localparam logic [DurW-1:0] GarbageLimitRst = 16'd10000;

  localparam logic [IdxW-1:0] NoMatchIdx = 5'd27;

  localparam logic [WordW-1:0] CodeTable [NumCodes] = '{
    32'h2525609F, 32'h25257887, 32'h2525807F, 32'h2525906F, 32'h25258877,
    32'h25259867, 32'h252540BF, 32'h252550AF, 32'h252548B7, 32'h252558A7,
    32'h2525C03F, 32'h2525D02F, 32'h2525C837, 32'h252505FA, 32'h252530CF,
    32'h252520DF, 32'h2525B04F, 32'h2525A05F, 32'h252504FB, 32'h252506F9,
    32'h252538C7, 32'h2525D827, 32'h252528D7, 32'h2525708F, 32'h25256897,
    32'h2525B847, 32'h2525A857
  };

  // first matching entry wins
  function automatic logic [IdxW-1:0] code_lookup(input logic [WordW-1:0] word);
    logic [IdxW-1:0] idx;
    idx = NoMatchIdx;
    for (int k = NumCodes - 1; k >= 0; k--) begin
      if (CodeTable[k] == word) begin
        idx = IdxW'(k);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/ir_pulse_distance_decoder_core.sv -----
// Result: a burst's last level waits in the input register until the result register
// is free, then its result is registered. Throughput: one level per cycle; the input
// and result registers decouple the sides; a stalled result holds only a later burst end.
// Reset: asynchronous, clears the burst state and both valid flags and restores
// the timing registers to their defaults.
// Depends on irpdd_pkg.
`default_nettype none

module ir_pulse_distance_decoder_core #(
  parameter int unsigned MAX_LEVELS = 128,
  parameter int unsigned DATA_BITS  = 32
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [1:0]                   cfg_idx_i,
  input  wire logic [irpdd_pkg::DurW-1:0]   cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         level_high_i,
  input  wire logic [irpdd_pkg::DurW-1:0]   duration_us_i,
  input  wire logic                         burst_end_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic [irpdd_pkg::WordW-1:0]       data_word_o,
  output logic [irpdd_pkg::IdxW-1:0]        button_index_o,
  output logic                              recognized_o,
  output logic                              frame_error_o
);

  localparam int unsigned DurW = irpdd_pkg::DurW;
  localparam int unsigned LvlW = irpdd_pkg::LvlW;
  localparam logic [LvlW-1:0] MaxLvl  = LvlW'(MAX_LEVELS);
  localparam logic [LvlW-1:0] MaxBit  = LvlW'(DATA_BITS);

  logic [DurW-1:0] one_thr_q, low_min_q, low_max_q, garbage_q;

  logic            s1_valid_q;
  logic            s1_high_q;
  logic [DurW-1:0] s1_dur_q;
  logic            s1_end_q;

  logic [LvlW-1:0]      lvl_q, lvl_d;
  logic [DurW-1:0]      pend_dur_q, pend_dur_d;
  logic                 pend_low_q, pend_low_d;
  logic [DATA_BITS-1:0] shift_q, shift_d;
  logic                 low_err_q, low_err_d;

  logic            out_free, s1_go, in_xfer;
  logic            in_range, pair_do;
  logic [LvlW-1:0] lvl_inc, pair_first;
  logic [LvlW-1:0] pair_bit;
  logic [DurW-1:0] d0, d1;
  logic            low0, low1, s1_low;
  logic            bad0, bad1, pair_err;

  logic [irpdd_pkg::WordW-1:0] word_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      one_thr_q <= irpdd_pkg::OneThresholdRst;
      low_min_q <= irpdd_pkg::LowMinRst;
      low_max_q <= irpdd_pkg::LowMaxRst;
      garbage_q <= irpdd_pkg::GarbageLimitRst;
    end else if (cfg_we_i) begin
      case (irpdd_pkg::cfg_reg_e'(cfg_idx_i))
        irpdd_pkg::REG_ONE_THRESHOLD: one_thr_q <= cfg_data_i;
        irpdd_pkg::REG_LOW_MIN:       low_min_q <= cfg_data_i;
        irpdd_pkg::REG_LOW_MAX:       low_max_q <= cfg_data_i;
        irpdd_pkg::REG_GARBAGE_LIMIT: garbage_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_free   = !out_valid_o || out_ready_i;
  assign s1_go      = s1_valid_q && (!s1_end_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_high_q <= level_high_i;
      s1_dur_q  <= duration_us_i;
      s1_end_q  <= burst_end_i;
    end
  end

  always_comb begin
    s1_low   = !s1_high_q;
    in_range = lvl_q < MaxLvl;
    lvl_inc  = in_range ? (lvl_q + LvlW'(1)) : lvl_q;

    pair_do    = 1'b0;
    pair_first = '0;
    d0         = pend_dur_q;
    low0       = pend_low_q;
    d1         = '0;
    low1       = 1'b0;
    if (in_range && lvl_q[0]) begin
      pair_do    = 1'b1;
      pair_first = lvl_q - LvlW'(1);
      d1         = s1_dur_q;
      low1       = s1_low;
    end else if (s1_end_q && lvl_inc[0]) begin
      pair_do    = 1'b1;
      pair_first = lvl_inc - LvlW'(1);
      if (in_range) begin
        d0   = s1_dur_q;
        low0 = s1_low;
      end
    end
    pair_bit = {1'b0, pair_first[LvlW-1:1]};

    bad0     = low0 && ((d0 < low_min_q) || (d0 > low_max_q));
    bad1     = low1 && ((d1 < low_min_q) || (d1 > low_max_q));
    pair_err = pair_do && (pair_bit != '0) && !(d0 > garbage_q || d1 > garbage_q)
               && (bad0 || bad1);

    shift_d = shift_q;
    if (pair_do && (pair_bit != '0) && (pair_bit <= MaxBit)) begin
      shift_d = (shift_q << 1) | DATA_BITS'(d1 > one_thr_q);
    end
    low_err_d = low_err_q || pair_err;

    pend_dur_d = pend_dur_q;
    pend_low_d = pend_low_q;
    if (in_range && !lvl_q[0]) begin
      pend_dur_d = s1_dur_q;
      pend_low_d = s1_low;
    end
    lvl_d = lvl_inc;

    word_full = irpdd_pkg::WordW'(shift_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q      <= '0;
      pend_dur_q <= '0;
      pend_low_q <= 1'b0;
      shift_q    <= '0;
      low_err_q  <= 1'b0;
    end else if (s1_go) begin
      if (s1_end_q) begin
        lvl_q      <= '0;
        pend_dur_q <= '0;
        pend_low_q <= 1'b0;
        shift_q    <= '0;
        low_err_q  <= 1'b0;
      end else begin
        lvl_q      <= lvl_d;
        pend_dur_q <= pend_dur_d;
        pend_low_q <= pend_low_d;
        shift_q    <= shift_d;
        low_err_q  <= low_err_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (out_free) begin
      out_valid_o <= s1_go && s1_end_q;
    end
  end

  logic [irpdd_pkg::IdxW-1:0] idx_res;
  logic                       rec_res;

  assign idx_res = irpdd_pkg::code_lookup(word_full);
  assign rec_res = idx_res != irpdd_pkg::NoMatchIdx;

  always_ff @(posedge clk_i) begin
    if (out_free && s1_go && s1_end_q) begin
      data_word_o    <= word_full;
      button_index_o <= idx_res;
      recognized_o   <= rec_res;
      frame_error_o  <= low_err_d || !rec_res;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/irpdd_checker.sv -----
// Port-level checks for ir_pulse_distance_decoder_core, bound into that module.
// Depends on irpdd_pkg.
`default_nettype none

module irpdd_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_o,
  input wire logic                         out_ready_i,
  input wire logic [irpdd_pkg::WordW-1:0]  data_word_o,
  input wire logic [irpdd_pkg::IdxW-1:0]   button_index_o,
  input wire logic                         recognized_o,
  input wire logic                         frame_error_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(data_word_o) && $stable(button_index_o))
    else $error("stalled result changed");

  a_rec_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && recognized_o |-> button_index_o < irpdd_pkg::NoMatchIdx)
    else $error("recognized result without table index");

  a_norec_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !recognized_o |->
      frame_error_o && button_index_o == irpdd_pkg::NoMatchIdx)
    else $error("unrecognized word not flagged");

endmodule

bind ir_pulse_distance_decoder_core irpdd_checker u_irpdd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .data_word_o    (data_word_o),
  .button_index_o (button_index_o),
  .recognized_o   (recognized_o),
  .frame_error_o  (frame_error_o)
);

`default_nettype wire
